FILE: hdl/scr_pkg.sv
`timescale 1ns / 1ps
// scr_pkg: types, constants and helpers shared by the cookie hash pipeline
// no dependencies

package scr_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 16;
  localparam int KEY_REGS    = 8;
  localparam int KEY_REG_W   = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int BIN_W       = 4;
  localparam int ROUNDS_DEF  = 6;
  localparam int STEPS       = 4;   // dependent updates in one quarter round
  localparam int QUARTERS    = 4;   // independent quarter rounds in one round

  typedef logic [WORD_W-1:0]                 word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  word_vec_t;
  typedef logic [CFG_IDX_W-1:0]              cfg_idx_t;
  typedef logic [KEY_REG_W-1:0]              key_reg_t;

  // operation codes
  localparam logic FUNC_GENERATE = 1'b0;
  localparam logic FUNC_VERIFY   = 1'b1;

  // side data that travels along with the state words
  typedef struct packed {
    logic  func;
    word_t tag;   // generate: epoch bin in bits 3:0, verify: cookie with bin cleared
  } side_t;

  typedef struct packed {
    logic  valid;
    side_t side;
  } stage_t;

  // word indexes of each quarter round: [0 column, 1 row round][quarter][position a,b,c,d]
  localparam int QIDX [2][QUARTERS][STEPS] = '{
    '{'{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11}},
    '{'{0, 1, 2, 3},  '{5, 6, 7, 4},  '{10, 11, 8, 9}, '{15, 12, 13, 14}}
  };

  // rotate amount of each step of a quarter round
  localparam int ROT_AMT [STEPS] = '{7, 9, 13, 18};

  function automatic word_t rotl(input word_t v, input int unsigned s);
    word_t res;
    res = (v << s) | (v >> (WORD_W - s));
    return res;
  endfunction

endpackage

FILE: hdl/scr_if.sv
`timescale 1ns / 1ps
// scr_in_if / scr_out_if: valid-ready channels for requests and results
// no dependencies

interface scr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] peer_address;
  logic [15:0] peer_port;
  logic [31:0] current_epoch;
  logic [31:0] cookie_in;

  modport source (output valid, func, peer_address, peer_port, current_epoch, cookie_in,
                  input ready);
  modport sink   (input valid, func, peer_address, peer_port, current_epoch, cookie_in,
                  output ready);
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cookie_out;
  logic        cookie_ok;

  modport source (output valid, cookie_out, cookie_ok, input ready);
  modport sink   (input valid, cookie_out, cookie_ok, output ready);
endinterface

FILE: hdl/scr_prep.sv
`timescale 1ns / 1ps
// scr_prep: key registers, epoch rebuild and key mixing, first pipeline register
// depends on scr_pkg and scr_in_if

module scr_prep
  import scr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  key_reg_t         cfg_data,
  scr_in_if.sink           in_ch,
  output stage_t           dn_o,
  output word_vec_t        dn_words_o,
  input  logic             dn_ready_i
);

  key_reg_t  key_r [KEY_REGS];
  stage_t    dn_r;
  word_vec_t words_r;
  word_vec_t words_nxt;
  side_t     side_nxt;
  word_t     ep_base;
  word_t     ep_nxt;
  logic      bin_ahead;
  logic      load;

  // key register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  // epoch rebuild for verify, step back one wrap when the bin is ahead
  always_comb begin
    ep_base   = {in_ch.current_epoch[WORD_W-1:BIN_W], in_ch.cookie_in[BIN_W-1:0]};
    bin_ahead = in_ch.cookie_in[BIN_W-1:0] > in_ch.current_epoch[BIN_W-1:0];
    if (in_ch.func == FUNC_GENERATE) begin
      ep_nxt = in_ch.current_epoch;
    end else if (bin_ahead) begin
      ep_nxt = ep_base - word_t'(1 << BIN_W);
    end else begin
      ep_nxt = ep_base;
    end
  end

  // initial state words and side data
  always_comb begin
    for (int i = 0; i < KEY_REGS; i++) begin
      words_nxt[2*i]   = key_r[i][WORD_W-1:0];
      words_nxt[2*i+1] = key_r[i][KEY_REG_W-1:WORD_W];
    end
    words_nxt[4]  = key_r[2][WORD_W-1:0] + in_ch.peer_address;
    words_nxt[6]  = key_r[3][WORD_W-1:0] + ep_nxt;
    words_nxt[8]  = key_r[4][WORD_W-1:0] + {16'b0, in_ch.peer_port};
    words_nxt[10] = key_r[5][WORD_W-1:0] + ep_nxt;
    side_nxt.func = in_ch.func;
    if (in_ch.func == FUNC_GENERATE) begin
      side_nxt.tag = {{(WORD_W-BIN_W){1'b0}}, in_ch.current_epoch[BIN_W-1:0]};
    end else begin
      side_nxt.tag = {in_ch.cookie_in[WORD_W-1:BIN_W], {BIN_W{1'b0}}};
    end
  end

  assign in_ch.ready = !dn_r.valid || dn_ready_i;
  assign load        = in_ch.ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_r.valid <= 1'b0;
    end else if (load) begin
      dn_r.valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_ch.valid) begin
      dn_r.side <= side_nxt;
      words_r   <= words_nxt;
    end
  end

  assign dn_o       = dn_r;
  assign dn_words_o = words_r;

endmodule

FILE: hdl/scr_cell.sv
`timescale 1ns / 1ps
// scr_cell: one add-rotate-xor step of four parallel quarter rounds, registered
// depends on scr_pkg

module scr_cell
  import scr_pkg::*;
#(
  parameter int ROW  = 0,   // 0 column round, 1 row round
  parameter int STEP = 0    // step within the quarter round, 0..3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  stage_t    up_i,
  input  word_vec_t up_words_i,
  output logic      up_ready_o,
  output stage_t    dn_o,
  output word_vec_t dn_words_o,
  input  logic      dn_ready_i
);

  localparam int POS_T = (STEP + 1) % STEPS;
  localparam int POS_A = STEP;
  localparam int POS_B = (STEP + 3) % STEPS;
  localparam int ROT   = ROT_AMT[STEP];

  stage_t    dn_r;
  word_vec_t words_r;
  word_vec_t words_nxt;

  // four independent quarter-round updates
  always_comb begin
    words_nxt = up_words_i;
    for (int q = 0; q < QUARTERS; q++) begin
      words_nxt[QIDX[ROW][q][POS_T]] = up_words_i[QIDX[ROW][q][POS_T]] ^
        rotl(up_words_i[QIDX[ROW][q][POS_A]] + up_words_i[QIDX[ROW][q][POS_B]], ROT);
    end
  end

  assign up_ready_o = !dn_r.valid || dn_ready_i;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_r.valid <= 1'b0;
    end else if (up_ready_o) begin
      dn_r.valid <= up_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_o && up_i.valid) begin
      dn_r.side <= up_i.side;
      words_r   <= words_nxt;
    end
  end

  assign dn_o       = dn_r;
  assign dn_words_o = words_r;

endmodule

FILE: hdl/scr_final.sv
`timescale 1ns / 1ps
// scr_final: diagonal xor, cookie format and compare, output register
// depends on scr_pkg and scr_out_if

module scr_final
  import scr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stage_t    up_i,
  input  word_vec_t up_words_i,
  output logic      up_ready_o,
  scr_out_if.source out_ch
);

  logic  valid_r;
  word_t cookie_r;
  logic  ok_r;
  word_t hash;
  word_t cookie_nxt;
  logic  ok_nxt;

  // hash and result fields
  always_comb begin
    hash = up_words_i[0] ^ up_words_i[5] ^ up_words_i[10] ^ up_words_i[15];
    if (up_i.side.func == FUNC_GENERATE) begin
      cookie_nxt = {hash[WORD_W-BIN_W-1:0], up_i.side.tag[BIN_W-1:0]};
      ok_nxt     = 1'b0;
    end else begin
      cookie_nxt = '0;
      ok_nxt     = hash[WORD_W-BIN_W-1:0] == up_i.side.tag[WORD_W-1:BIN_W];
    end
  end

  assign up_ready_o = !valid_r || out_ch.ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready_o) begin
      valid_r <= up_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_o && up_i.valid) begin
      cookie_r <= cookie_nxt;
      ok_r     <= ok_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.cookie_out = cookie_r;
  assign out_ch.cookie_ok  = ok_r;

endmodule

FILE: hdl/salsa_round_cookie_generate_verify.sv
`timescale 1ns / 1ps
// salsa_round_cookie_generate_verify: cookie generate and verify on a reduced Salsa20 core
// each item passes the scr_prep register, every cell and the scr_final output register
// one item per cycle unless stalled; 8*(ROUNDS/2) cells, one add-rotate-xor step each
// stalls move back stage by stage, empty stages fill while the output waits
// reset (rst_n, synchronous): clears key registers to zero and all stage valid bits
// depends on scr_pkg, scr_if, scr_prep, scr_cell, scr_final

module salsa_round_cookie_generate_verify
  import scr_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  key_reg_t  cfg_data,
  scr_in_if.sink    in_ch,
  scr_out_if.source out_ch
);

  localparam int NCELLS = 2 * STEPS * (ROUNDS / 2);

  stage_t    st   [NCELLS+1];
  word_vec_t wv   [NCELLS+1];
  logic      rdy  [NCELLS+1];

  // key mixing and first stage
  scr_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .dn_o       (st[0]),
    .dn_words_o (wv[0]),
    .dn_ready_i (rdy[0])
  );

  // row of round cells
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    scr_cell #(
      .ROW  ((k / STEPS) % 2),
      .STEP (k % STEPS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_i       (st[k]),
      .up_words_i (wv[k]),
      .up_ready_o (rdy[k]),
      .dn_o       (st[k+1]),
      .dn_words_o (wv[k+1]),
      .dn_ready_i (rdy[k+1])
    );
  end

  // hash reduction and result register
  scr_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_i       (st[NCELLS]),
    .up_words_i (wv[NCELLS]),
    .up_ready_o (rdy[NCELLS]),
    .out_ch     (out_ch)
  );

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // a generate never reports a match, a verify never returns a cookie
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.cookie_ok |-> out_ch.cookie_out == '0)
    else $error("both result fields set");

  // input backpressure only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  // a new result comes only from the last cell
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(st[NCELLS].valid))
    else $error("result without an item in the last cell");

endmodule
